### hw/rtl/packed_bitmap_pixel_access_unit_macros.svh
// Assertion helpers for the pixel access unit checker.
// Both expect clk and rst_n in the enclosing scope.
`ifndef PACKED_BITMAP_PIXEL_ACCESS_UNIT_MACROS_SVH
`define PACKED_BITMAP_PIXEL_ACCESS_UNIT_MACROS_SVH

// same-cycle implication
`define PBPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pbpa_pkg.sv
package pbpa_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH    = 2'd2;

  localparam logic       MODE_1BPP  = 1'b0;
  localparam logic       MODE_4BPP  = 1'b1;
  localparam logic [8:0] HEIGHT_RST = 9'd256;
  localparam logic [7:0] PITCH_RST  = 8'd32;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  localparam logic [7:0] PIX_MSB = 8'h80;
  localparam logic [7:0] LO_NIB  = 8'h0f;
  localparam logic [7:0] HI_NIB  = 8'hf0;

  localparam int BASE_W = 17;
  localparam int SUM_W  = 18;

  typedef struct packed {
    logic       wide;
    logic [8:0] height;
    logic [7:0] pitch;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic              wide;
    logic [2:0]        xlo;
    logic [3:0]        color;
    logic [7:0]        colbyte;
    logic [BASE_W-1:0] base;
    logic              bad;
  } q_entry_t;

  typedef struct packed {
    logic       cmd;
    logic       wide;
    logic [2:0] xlo;
    logic [3:0] color;
  } job_t;

  typedef struct packed {
    logic clr_busy;
  } bk_status_t;

endpackage

### hw/rtl/pbpa_ifs.sv
interface pbpa_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [3:0] color;

  modport source (output valid, command, pos_x, pos_y, color, input ready);
  modport sink (input valid, command, pos_x, pos_y, color, output ready);
endinterface

interface pbpa_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_value;
  logic       out_of_range;

  modport source (output valid, pixel_value, out_of_range, input ready);
  modport sink (input valid, pixel_value, out_of_range, output ready);
endinterface

interface pbpa_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/pbpa_front.sv
module pbpa_front (
  pbpa_in_if.sink              in_ch,
  input  pbpa_pkg::cfg_t       cfg,
  input  pbpa_pkg::bk_status_t bk_status,
  input  logic                 q_full,
  output logic                 push,
  output pbpa_pkg::q_entry_t   push_data
);
  import pbpa_pkg::*;

  logic [7:0] colbyte;
  logic [8:0] rows;
  logic       bad_row;
  logic       bad_col;

  assign in_ch.ready = !q_full && !bk_status.clr_busy;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    colbyte = (cfg.wide == MODE_4BPP) ? {1'b0, in_ch.pos_x[7:1]} : {3'b000, in_ch.pos_x[7:3]};
    bad_row = ({1'b0, in_ch.pos_y} >= cfg.height);
    bad_col = (colbyte >= cfg.pitch);
    rows    = cfg.height - 9'd1 - {1'b0, in_ch.pos_y};

    push_data.cmd     = in_ch.command;
    push_data.wide    = cfg.wide;
    push_data.xlo     = in_ch.pos_x[2:0];
    push_data.color   = in_ch.color;
    push_data.colbyte = colbyte;
    push_data.base    = BASE_W'(rows) * BASE_W'(cfg.pitch);
    push_data.bad     = bad_row || bad_col;
  end

endmodule

### hw/rtl/pbpa_queue.sv
module pbpa_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pbpa_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output pbpa_pkg::q_entry_t pop_data
);
  import pbpa_pkg::*;

  q_entry_t   ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign pop_data = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/pbpa_back.sv
module pbpa_back #(
  parameter int STORE_BYTES = 8192
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  pbpa_pkg::q_entry_t   q_data,
  output logic                 pop,
  pbpa_out_if.source           out_ch,
  output pbpa_pkg::bk_status_t bk_status
);
  import pbpa_pkg::*;

  localparam int                AW       = $clog2(STORE_BYTES);
  localparam logic [AW-1:0]     LAST     = AW'(STORE_BYTES - 1);
  localparam logic [SUM_W-1:0]  STORE_LIM = SUM_W'(STORE_BYTES);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_MOD  = 2'd3;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [AW-1:0]    clr_cnt_r;
  job_t             job_r;
  logic [AW-1:0]    addr_r;
  logic             bad_r;
  logic [7:0]       rdata_r;
  logic [7:0]       mem [STORE_BYTES];

  logic [SUM_W-1:0] sum;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [7:0]       bit_mask;
  logic [7:0]       new_byte;
  logic [3:0]       pix;
  logic             finish;

  logic             out_valid_r;
  logic [3:0]       out_pix_r;
  logic             out_oor_r;

  assign sum      = {1'b0, q_data.base} + SUM_W'(q_data.colbyte);
  assign pop      = (state_r == S_IDLE) && q_valid;
  assign finish   = (state_r == S_MOD) && (!out_valid_r || out_ch.ready);
  assign bit_mask = PIX_MSB >> job_r.xlo;

  always_comb begin
    pix      = 4'd0;
    new_byte = rdata_r;
    if (job_r.wide == MODE_4BPP) begin
      if (job_r.xlo[0]) begin
        pix      = rdata_r[3:0];
        new_byte = (rdata_r & HI_NIB) | {4'b0000, job_r.color};
      end else begin
        pix      = rdata_r[7:4];
        new_byte = (rdata_r & LO_NIB) | {job_r.color, 4'b0000};
      end
    end else begin
      pix      = {3'b000, ((rdata_r & bit_mask) != 8'd0)};
      new_byte = rdata_r | bit_mask;
    end
    if (bad_r || job_r.cmd == CMD_SET) begin
      pix = 4'd0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = new_byte;
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = 8'd0;
    end else if (finish && !bad_r && job_r.cmd == CMD_SET && job_r.color != 4'd0) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_cnt_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r.cmd   <= q_data.cmd;
      job_r.wide  <= q_data.wide;
      job_r.xlo   <= q_data.xlo;
      job_r.color <= q_data.color;
      addr_r      <= sum[AW-1:0];
      bad_r       <= q_data.bad || (sum >= STORE_LIM);
    end
    if (finish) begin
      out_pix_r <= pix;
      out_oor_r <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_RD) begin
      rdata_r <= mem[addr_r];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_value  = out_pix_r;
  assign out_ch.out_of_range = out_oor_r;

  assign bk_status.clr_busy = (state_r == S_CLR);

endmodule

### hw/rtl/packed_bitmap_pixel_access_unit.sv
// Pixel read/write port over a byte frame store holding a bottom-up packed
// bitmap, 1 bit per pixel (MSB first) or 4 bits per pixel (even x = high nibble).
// Channels: in_ch takes items {command, pos_x, pos_y, color}; out_ch returns
// one item {pixel_value, out_of_range} per input item, in order; cfg_ch writes
// color_mode (index 0), image_height (1) and row_pitch (2), always ready,
// and must only be written while no item is in flight.
// Processing: the back end reads the byte, then modifies and writes it, over
// the single-port store, one item at a time.
// A two-entry queue between front and back lets in_ch keep accepting while
// the back end works or waits.
// Reset: config returns to 1 bpp, height 256, pitch 32, and the store is
// cleared one byte a cycle, with in_ch.ready low meanwhile.
// Stall: out_ch holds its item while ready is low; the back end stops after
// finishing its current read, and in_ch.ready drops once the queue fills.
module packed_bitmap_pixel_access_unit #(
  parameter int STORE_BYTES = 8192
) (
  input  logic       clk,
  input  logic       rst_n,
  pbpa_in_if.sink    in_ch,
  pbpa_out_if.source out_ch,
  pbpa_cfg_if.sink   cfg_ch
);
  import pbpa_pkg::*;

  cfg_t       cfg_r;
  q_entry_t   push_data;
  q_entry_t   pop_data;
  bk_status_t bk_status;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide   <= MODE_1BPP;
      cfg_r.height <= HEIGHT_RST;
      cfg_r.pitch  <= PITCH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_COLOR_MODE:   cfg_r.wide   <= cfg_ch.data[0];
        CFG_IMAGE_HEIGHT: cfg_r.height <= cfg_ch.data;
        CFG_ROW_PITCH:    cfg_r.pitch  <= cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end
  end

  pbpa_front u_front (
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .bk_status (bk_status),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pbpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (pop_data)
  );

  pbpa_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .pop       (pop),
    .out_ch    (out_ch),
    .bk_status (bk_status)
  );

endmodule

### hw/rtl/pbpa_checker.sv
`include "packed_bitmap_pixel_access_unit_macros.svh"

module pbpa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_pixel_value,
  input logic       out_out_of_range
);

  logic [2:0] pend_r;
  logic [2:0] pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `PBPA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `PBPA_ASSERT_IMP(a_oor_zero, out_valid && out_out_of_range, out_pixel_value == 4'd0, "oor pixel nonzero")
  `PBPA_ASSERT_IMP(a_no_extra, out_valid, pend_r != 3'd0, "result without pending item")
  `PBPA_ASSERT_IMP(a_pend_max, in_acc, pend_r < 3'd4, "too many items in flight")

endmodule

bind packed_bitmap_pixel_access_unit pbpa_checker u_pbpa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_pixel_value  (out_ch.pixel_value),
  .out_out_of_range (out_ch.out_of_range)
);
